### rtl/core/linked_ring_queue_manager_macros.svh
// assertion macros for the linked ring queue manager
// used by the sequencer, no other dependencies
`ifndef LINKED_RING_QUEUE_MANAGER_MACROS_SVH
`define LINKED_RING_QUEUE_MANAGER_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define LRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define LRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define LRQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/lrq_pkg.sv
// shared constants, codes and structs of the linked ring queue manager
// no dependencies
package lrq_pkg;

    localparam int POOL_NODES = 64;
    localparam int QUEUES     = 4;
    localparam int REF_BITS   = 32;
    localparam int NODE_W     = $clog2(POOL_NODES);
    localparam int Q_W        = $clog2(QUEUES);
    localparam int FC_W       = $clog2(POOL_NODES + 1);
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SHIFT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD   = 2'd3;

    // sequencer to pool: read and write requests
    typedef struct packed {
        logic                rd_en;
        logic [NODE_W-1:0]   nl_raddr;
        logic [NODE_W-1:0]   pl_raddr;
        logic                nl_we;
        logic [NODE_W-1:0]   nl_waddr;
        logic [NODE_W-1:0]   nl_wdata;
        logic                pl_we;
        logic [NODE_W-1:0]   pl_waddr;
        logic [NODE_W-1:0]   pl_wdata;
        logic                node_we;
        logic [NODE_W-1:0]   node_waddr;
        logic [REF_BITS-1:0] ref_wdata;
        logic [Q_W-1:0]      own_wdata;
    } t_pool_req;

    // pool to sequencer: registered read data
    typedef struct packed {
        logic [NODE_W-1:0]   next_node;
        logic [NODE_W-1:0]   prev_node;
        logic [REF_BITS-1:0] ref_data;
        logic [Q_W-1:0]      owner;
    } t_pool_rd;

    // one result word
    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [REF_BITS-1:0] ref_out;
        logic [NODE_W-1:0]   node_out;
        logic                now_empty;
    } t_result;

endpackage

### rtl/core/linked_ring_queue_manager.sv
// Flow: an accepted word passes the execute and final states of the sequencer into the
// output register; no new word is taken until the final step is done, and a stalled
// result holds the final step, after the read and link-write steps of the sequencer.
// Reset: synchronous, active low; queues empty, free list restored at once, ready next cycle.
// top level: output register, sequencer and node pool; depends on lrq_pkg, lrq_seq, lrq_pool
module linked_ring_queue_manager (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [lrq_pkg::CMD_W-1:0]    i_command,
    input  logic [lrq_pkg::Q_W-1:0]      i_queue_id,
    input  logic [lrq_pkg::REF_BITS-1:0] i_ref_value,
    input  logic [lrq_pkg::NODE_W-1:0]   i_node_handle,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lrq_pkg::STAT_W-1:0]   o_status,
    output logic [lrq_pkg::REF_BITS-1:0] o_ref_out,
    output logic [lrq_pkg::NODE_W-1:0]   o_node_out,
    output logic                         o_queue_now_empty
);
    import lrq_pkg::*;

    t_pool_req pool_req;
    t_pool_rd  pool_rd;
    t_result   res;
    logic      res_load;
    logic      fin_go;
    logic      busy;
    logic      r_out_valid;
    t_result   r_out;

    // result slot free when empty or being taken
    assign fin_go = !r_out_valid || !i_out_stall;

    lrq_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_busy        (busy),
        .i_command     (i_command),
        .i_queue_id    (i_queue_id),
        .i_ref_value   (i_ref_value),
        .i_node_handle (i_node_handle),
        .i_fin_go      (fin_go),
        .o_res_load    (res_load),
        .o_res         (res),
        .o_pool        (pool_req),
        .i_rd          (pool_rd)
    );

    lrq_pool u_pool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (pool_req),
        .o_rd    (pool_rd)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_in_stall        = busy;
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out.status;
    assign o_ref_out         = r_out.ref_out;
    assign o_node_out        = r_out.node_out;
    assign o_queue_now_empty = r_out.now_empty;

endmodule

### rtl/core/lrq_pool.sv
// node pool memories: next link, prev link, reference and owner
// depends on lrq_pkg
module lrq_pool (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lrq_pkg::t_pool_req i_req,
    output lrq_pkg::t_pool_rd  o_rd
);
    import lrq_pkg::*;

    logic [NODE_W-1:0]   nl_mem  [POOL_NODES];
    logic [NODE_W-1:0]   pl_mem  [POOL_NODES];
    logic [REF_BITS-1:0] ref_mem [POOL_NODES];
    logic [Q_W-1:0]      own_mem [POOL_NODES];

    logic [POOL_NODES-1:0] r_nl_written;
    t_pool_rd              r_rd;
    logic [NODE_W-1:0]     nl_succ;

    // reset chain of the free list: node i links to i+1, last wraps to 0
    assign nl_succ = (i_req.nl_raddr == NODE_W'(POOL_NODES - 1)) ?
                     '0 : i_req.nl_raddr + NODE_W'(1);

    // written flags for the next link store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nl_written <= '0;
        end else if (i_req.nl_we) begin
            r_nl_written[i_req.nl_waddr] <= 1'b1;
        end
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_req.nl_we) begin
            nl_mem[i_req.nl_waddr] <= i_req.nl_wdata;
        end
        if (i_req.pl_we) begin
            pl_mem[i_req.pl_waddr] <= i_req.pl_wdata;
        end
        if (i_req.node_we) begin
            ref_mem[i_req.node_waddr] <= i_req.ref_wdata;
            own_mem[i_req.node_waddr] <= i_req.own_wdata;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd.next_node <= r_nl_written[i_req.nl_raddr] ?
                              nl_mem[i_req.nl_raddr] : nl_succ;
            r_rd.prev_node <= pl_mem[i_req.pl_raddr];
            r_rd.ref_data  <= ref_mem[i_req.nl_raddr];
            r_rd.owner     <= own_mem[i_req.nl_raddr];
        end
    end

    assign o_rd = r_rd;

endmodule

### rtl/core/lrq_seq.sv
// operation sequencer: queue heads, free list, node flags and link updates
// depends on lrq_pkg and linked_ring_queue_manager_macros.svh
`include "linked_ring_queue_manager_macros.svh"
module lrq_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_busy,
    input  logic [lrq_pkg::CMD_W-1:0]    i_command,
    input  logic [lrq_pkg::Q_W-1:0]      i_queue_id,
    input  logic [lrq_pkg::REF_BITS-1:0] i_ref_value,
    input  logic [lrq_pkg::NODE_W-1:0]   i_node_handle,
    input  logic                         i_fin_go,
    output logic                         o_res_load,
    output lrq_pkg::t_result             o_res,
    output lrq_pkg::t_pool_req           o_pool,
    input  lrq_pkg::t_pool_rd            i_rd
);
    import lrq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXE  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]            r_state,     n_state;
    logic [CMD_W-1:0]      r_cmd,       n_cmd;
    logic [Q_W-1:0]        r_q,         n_q;
    logic [REF_BITS-1:0]   r_ref,       n_ref;
    logic [NODE_W-1:0]     r_x,         n_x;
    logic [NODE_W-1:0]     r_hd,        n_hd;
    logic [NODE_W-1:0]     r_tl,        n_tl;
    logic                  r_do_link,   n_do_link;
    logic                  r_do_rel,    n_do_rel;
    logic [STAT_W-1:0]     r_status,    n_status;
    logic [REF_BITS-1:0]   r_rout,      n_rout;
    logic [NODE_W-1:0]     r_nout,      n_nout;
    logic [NODE_W-1:0]     r_free_head, n_free_head;
    logic [FC_W-1:0]       r_free_count, n_free_count;
    logic [POOL_NODES-1:0] r_in_use,    n_in_use;
    logic [NODE_W-1:0]     r_head [QUEUES];
    logic [NODE_W-1:0]     n_head [QUEUES];
    logic [QUEUES-1:0]     r_nonempty,  n_nonempty;

    logic [NODE_W-1:0]     x_sel;

    // node the incoming word works on
    always_comb begin
        unique case (i_command)
            CMD_PUSH:   x_sel = r_free_head;
            CMD_SHIFT:  x_sel = r_head[i_queue_id];
            CMD_REMOVE: x_sel = i_node_handle;
            CMD_NONE:   x_sel = i_node_handle;
        endcase
    end

    // sequencer: read at accept, first link writes, then final writes
    always_comb begin
        logic unlink;
        unlink       = 1'b0;
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_q          = r_q;
        n_ref        = r_ref;
        n_x          = r_x;
        n_hd         = r_hd;
        n_tl         = r_tl;
        n_do_link    = r_do_link;
        n_do_rel     = r_do_rel;
        n_status     = r_status;
        n_rout       = r_rout;
        n_nout       = r_nout;
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        n_in_use     = r_in_use;
        n_head       = r_head;
        n_nonempty   = r_nonempty;
        o_res_load   = 1'b0;

        o_pool          = '0;
        o_pool.rd_en    = (r_state == ST_IDLE);
        o_pool.nl_raddr = x_sel;
        o_pool.pl_raddr = (i_command == CMD_PUSH) ? r_head[i_queue_id] : x_sel;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXE;
                    n_cmd   = i_command;
                    n_q     = i_queue_id;
                    n_ref   = i_ref_value;
                    n_x     = x_sel;
                    n_hd    = r_head[i_queue_id];
                end
            end
            ST_EXE: begin
                n_state   = ST_FIN;
                n_do_link = 1'b0;
                n_do_rel  = 1'b0;
                n_status  = STAT_OK;
                n_rout    = '0;
                n_nout    = '0;
                unique case (r_cmd)
                    CMD_PUSH: begin
                        if (r_free_count == '0) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_nout             = r_x;
                            n_free_head        = i_rd.next_node;
                            n_free_count       = r_free_count - FC_W'(1);
                            n_in_use[r_x]      = 1'b1;
                            o_pool.node_we     = 1'b1;
                            o_pool.node_waddr  = r_x;
                            o_pool.ref_wdata   = r_ref;
                            o_pool.own_wdata   = r_q;
                            o_pool.nl_we       = 1'b1;
                            o_pool.nl_waddr    = r_x;
                            o_pool.pl_we       = 1'b1;
                            o_pool.pl_waddr    = r_x;
                            if (!r_nonempty[r_q]) begin
                                n_head[r_q]     = r_x;
                                n_nonempty[r_q] = 1'b1;
                                o_pool.nl_wdata = r_x;
                                o_pool.pl_wdata = r_x;
                            end else begin
                                // new node sits between tail and head
                                o_pool.nl_wdata = r_hd;
                                o_pool.pl_wdata = i_rd.prev_node;
                                n_tl            = i_rd.prev_node;
                                n_do_link       = 1'b1;
                            end
                        end
                    end
                    CMD_SHIFT: begin
                        if (!r_nonempty[r_q]) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            unlink = 1'b1;
                            n_rout = i_rd.ref_data;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!r_in_use[r_x] || (i_rd.owner != r_q)) begin
                            n_status = STAT_BAD;
                        end else begin
                            unlink = 1'b1;
                        end
                    end
                    CMD_NONE: begin
                    end
                endcase
                // take the node out of its ring
                if (unlink) begin
                    n_do_rel = 1'b1;
                    if (r_head[r_q] == r_x) begin
                        if (i_rd.next_node == r_x) begin
                            n_nonempty[r_q] = 1'b0;
                        end else begin
                            n_head[r_q] = i_rd.next_node;
                        end
                    end
                    o_pool.pl_we    = 1'b1;
                    o_pool.pl_waddr = i_rd.next_node;
                    o_pool.pl_wdata = i_rd.prev_node;
                    o_pool.nl_we    = 1'b1;
                    o_pool.nl_waddr = i_rd.prev_node;
                    o_pool.nl_wdata = i_rd.next_node;
                end
            end
            ST_FIN: begin
                if (i_fin_go) begin
                    n_state    = ST_IDLE;
                    o_res_load = 1'b1;
                    // close the ring behind a pushed node
                    if (r_do_link) begin
                        o_pool.nl_we    = 1'b1;
                        o_pool.nl_waddr = r_tl;
                        o_pool.nl_wdata = r_x;
                        o_pool.pl_we    = 1'b1;
                        o_pool.pl_waddr = r_hd;
                        o_pool.pl_wdata = r_x;
                    end
                    // freed node goes to the front of the free list
                    if (r_do_rel) begin
                        o_pool.nl_we    = 1'b1;
                        o_pool.nl_waddr = r_x;
                        o_pool.nl_wdata = r_free_head;
                        o_pool.pl_we    = 1'b1;
                        o_pool.pl_waddr = r_x;
                        o_pool.pl_wdata = r_x;
                        n_free_head     = r_x;
                        n_free_count    = r_free_count + FC_W'(1);
                        n_in_use[r_x]   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_do_link    <= 1'b0;
            r_do_rel     <= 1'b0;
            r_free_head  <= '0;
            r_free_count <= FC_W'(POOL_NODES);
            r_in_use     <= '0;
            r_nonempty   <= '0;
            for (int i = 0; i < QUEUES; i++) begin
                r_head[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_do_link    <= n_do_link;
            r_do_rel     <= n_do_rel;
            r_free_head  <= n_free_head;
            r_free_count <= n_free_count;
            r_in_use     <= n_in_use;
            r_nonempty   <= n_nonempty;
            r_head       <= n_head;
        end
    end

    // operation payload
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_q      <= n_q;
        r_ref    <= n_ref;
        r_x      <= n_x;
        r_hd     <= n_hd;
        r_tl     <= n_tl;
        r_status <= n_status;
        r_rout   <= n_rout;
        r_nout   <= n_nout;
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_res.status    = r_status;
    assign o_res.ref_out   = r_rout;
    assign o_res.node_out  = r_nout;
    assign o_res.now_empty = !r_nonempty[r_q];

    // node accounting and sequencing checks
    `LRQ_ASSERT(a_node_count, i_clk, i_rst_n, ($countones(r_in_use) + int'(r_free_count) == POOL_NODES), "free count and allocated nodes disagree")
    `LRQ_ASSERT(a_fin_hold, i_clk, i_rst_n, ((r_state == ST_FIN) && !i_fin_go) |=> (r_state == ST_FIN), "final step left while result slot busy")
    `LRQ_ASSERT(a_idle_hold, i_clk, i_rst_n, ((r_state == ST_IDLE) && !i_in_valid) |=> (r_state == ST_IDLE), "sequencer started without a word")
    `LRQ_ASSERT(a_link_rel_excl, i_clk, i_rst_n, (r_state == ST_FIN) |-> !(r_do_link && r_do_rel), "link and release in one operation")

endmodule
